// ----- hdl/lss_pkg.sv -----
// shared constants, widths and type definitions of the trial beta solver
`timescale 1ns / 1ps
package lss_pkg;
	// store geometry
	localparam int MAX_ROWS   = 256;
	localparam int MAX_TRIALS = 64;
	localparam int MAX_VOXELS = 64;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int TRIAL_W    = $clog2(MAX_TRIALS);
	localparam int VOX_W      = $clog2(MAX_VOXELS);
	localparam int RCNT_W     = $clog2(MAX_ROWS + 1);
	localparam int TCNT_W     = $clog2(MAX_TRIALS + 1);

	// configuration port
	localparam int CFG_W       = 40;
	localparam int CFG_IDX_W   = 2;
	localparam int ROWCFG_W    = 9;
	localparam int TRIALCFG_W  = 7;
	localparam int MINDEN_W    = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIALS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEN = 2'd2;

	// arithmetic widths
	localparam int VAL_W   = 16;
	localparam int S_W     = VAL_W + TRIAL_W;
	localparam int PROD_W  = 2 * S_W;
	localparam int SS_W    = PROD_W + ROW_W;
	localparam int CTY_W   = 2 * VAL_W + ROW_W;
	localparam int C2_W    = CTY_W;
	localparam int CS_W    = VAL_W + S_W + ROW_W;
	localparam int MUL_W   = SS_W;
	localparam int NUM_W   = CTY_W + SS_W + 2;
	localparam int QF_SH   = 17;
	localparam int DN_W    = NUM_W + QF_SH;
	localparam int DD_W    = NUM_W + 1;
	localparam int BETA_W  = 32;

	// request codes
	typedef enum logic [1:0] {
		REQ_DESIGN = 2'd0,
		REQ_DATA   = 2'd1,
		REQ_QUERY  = 2'd2
	} req_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_YRD,
		ST_YWAIT,
		ST_MUL,
		ST_DRAIN,
		ST_BIG_GO,
		ST_BIG_WAIT,
		ST_CHECK,
		ST_DIV_GO,
		ST_DIV_WAIT
	} st_t;

	// row product phases
	typedef enum logic [2:0] {
		PH_SS  = 3'd0,
		PH_CTY = 3'd1,
		PH_CS  = 3'd2,
		PH_SCY = 3'd3,
		PH_C2  = 3'd4
	} ph_t;

	// wide product steps
	typedef enum logic [1:0] {
		BP_CTY_SS  = 2'd0,
		BP_CS_SCY  = 2'd1,
		BP_C2_SS   = 2'd2,
		BP_CS_CS   = 2'd3
	} bp_t;
endpackage

// ----- hdl/lss_smul.sv -----
// shift-add serial multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module lss_smul import lss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic                 done,
	output logic [2*MUL_W-1:0]   prod
);
	localparam int CW = $clog2(MUL_W + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(MUL_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [2*MUL_W-1:0] a_q;
	logic [MUL_W-1:0]  b_q;
	logic [2*MUL_W-1:0] p_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// add and shift
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= {{MUL_W{1'b0}}, a};
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) p_q <= p_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = p_q;
endmodule

// ----- hdl/lss_div.sv -----
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lss_div import lss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DN_W-1:0]   num,
	input  logic [DD_W-1:0]   den,
	output logic              done,
	output logic [DN_W-1:0]   quo
);
	localparam int CW = $clog2(DN_W + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(DN_W - 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [DN_W-1:0] n_q;
	logic [DN_W-1:0] q_q;
	logic [DD_W-1:0] r_q;
	logic [DD_W-1:0] d_q;
	logic [DD_W:0]   trial;
	logic            fits;

	// next partial remainder
	assign trial = {r_q, n_q[DN_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// compare, subtract, shift
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (fits) begin
				r_q <= DD_W'(trial - {1'b0, d_q});
				q_q <= {q_q[DN_W-2:0], 1'b1};
			end else begin
				r_q <= trial[DD_W-1:0];
				q_q <= {q_q[DN_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule

// ----- hdl/lss_trial_beta_solver.sv -----
// top level: matrix stores, row sequencer and beta evaluation
// Loads of a design or data element leave busy low. A query keeps busy high
// until its result is given out: each row reads the design store once per
// trial through its single read port and then runs five products through one
// 22x22 multiplier; the four wide products go through a bit-serial multiplier
// and the quotient through a bit-serial divider. A query whose trial is not in
// use returns at once. The result appears with done for one cycle and is not
// held: the receiver must take it then. Store entries must be written before
// a query reads them.
`timescale 1ns / 1ps
module lss_trial_beta_solver import lss_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              req_type,
	input  logic [ROW_W-1:0]        row,
	input  logic [TRIAL_W-1:0]      column,
	input  logic signed [VAL_W-1:0] value,
	input  logic [TRIAL_W-1:0]      trial_index,
	input  logic [VOX_W-1:0]        voxel_index,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    done,
	output logic signed [BETA_W-1:0] beta,
	output logic                    undefined,
	output logic [TRIAL_W-1:0]      trial_out,
	output logic [VOX_W-1:0]        voxel_out
);
	localparam logic [RCNT_W-1:0]     ROWS_MAX   = RCNT_W'(MAX_ROWS);
	localparam logic [TCNT_W-1:0]     TRIALS_MAX = TCNT_W'(MAX_TRIALS);
	localparam logic [BETA_W-1:0]     LIM_POS    = {1'b0, {(BETA_W-1){1'b1}}};
	localparam logic [BETA_W-1:0]     LIM_NEG    = {1'b1, {(BETA_W-1){1'b0}}};

	// configuration registers
	logic [ROWCFG_W-1:0]   rows_cfg_q;
	logic [TRIALCFG_W-1:0] trials_cfg_q;
	logic [MINDEN_W-1:0]   min_den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q   <= ROWCFG_W'(256);
			trials_cfg_q <= TRIALCFG_W'(64);
			min_den_q    <= MINDEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS:    rows_cfg_q   <= cfg_data[ROWCFG_W-1:0];
				CFG_TRIALS:  trials_cfg_q <= cfg_data[TRIALCFG_W-1:0];
				CFG_MIN_DEN: min_den_q    <= cfg_data[MINDEN_W-1:0];
				default: ;
			endcase
		end
	end

	// effective counts, clipped to the store size
	logic [RCNT_W-1:0] rows_eff;
	logic [TCNT_W-1:0] trials_eff;
	assign rows_eff   = (RCNT_W'(rows_cfg_q) > ROWS_MAX) ? ROWS_MAX : RCNT_W'(rows_cfg_q);
	assign trials_eff = (TCNT_W'(trials_cfg_q) > TRIALS_MAX) ? TRIALS_MAX
	                    : TCNT_W'(trials_cfg_q);

	// sequencer registers
	st_t               state_q, state_d;
	logic [RCNT_W-1:0] i_q;
	logic [TCNT_W-1:0] k_q;
	logic [2:0]        ph_q;
	logic [1:0]        bp_q;
	logic [TRIAL_W-1:0] t_q;
	logic [VOX_W-1:0]  v_q;

	logic accept;
	logic q_in_range;
	logic last_k;
	logic last_row;
	logic mul_done;
	logic div_done;
	logic undef_now;

	assign accept     = start && !busy;
	assign q_in_range = TCNT_W'(trial_index) < trials_eff;
	assign last_k     = k_q == (trials_eff - 1'b1);
	assign last_row   = i_q == (rows_eff - 1'b1);

	// stores
	logic signed [VAL_W-1:0] design_mem [0:MAX_ROWS*MAX_TRIALS-1];
	logic signed [VAL_W-1:0] data_mem   [0:MAX_ROWS*MAX_VOXELS-1];
	logic signed [VAL_W-1:0] design_rd_q;
	logic signed [VAL_W-1:0] data_rd_q;
	logic [ROW_W+TRIAL_W-1:0] design_raddr;
	logic [ROW_W+VOX_W-1:0]   data_raddr;
	logic design_we;
	logic data_we;

	assign design_we    = accept && (req_type == REQ_DESIGN);
	assign data_we      = accept && (req_type == REQ_DATA);
	assign design_raddr = {i_q[ROW_W-1:0], k_q[TRIAL_W-1:0]};
	assign data_raddr   = {i_q[ROW_W-1:0], v_q};

	always_ff @(posedge clk) begin
		if (design_we) design_mem[{row, column}] <= value;
		design_rd_q <= design_mem[design_raddr];
	end

	always_ff @(posedge clk) begin
		if (data_we) data_mem[{row, column[VOX_W-1:0]}] <= value;
		data_rd_q <= data_mem[data_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req_type == REQ_QUERY && q_in_range) begin
					state_d = (rows_eff == '0) ? ST_BIG_GO : ST_SUM;
				end
			end
			ST_SUM:      if (last_k) state_d = ST_YRD;
			ST_YRD:      state_d = ST_YWAIT;
			ST_YWAIT:    state_d = ST_MUL;
			ST_MUL: begin
				if (ph_q == PH_C2) state_d = last_row ? ST_DRAIN : ST_SUM;
			end
			ST_DRAIN:    state_d = ST_BIG_GO;
			ST_BIG_GO:   state_d = ST_BIG_WAIT;
			ST_BIG_WAIT: begin
				if (mul_done) state_d = (bp_q == BP_CS_CS) ? ST_CHECK : ST_BIG_GO;
			end
			ST_CHECK:    state_d = undef_now ? ST_IDLE : ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	logic mul_start;
	logic div_start;
	always_comb begin
		busy      = 1'b1;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:   busy      = 1'b0;
			ST_BIG_GO: mul_start = 1'b1;
			ST_DIV_GO: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// counters and query indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q  <= '0;
			k_q  <= '0;
			ph_q <= '0;
			bp_q <= '0;
			t_q  <= '0;
			v_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					i_q  <= '0;
					k_q  <= '0;
					ph_q <= '0;
					bp_q <= '0;
					if (accept) begin
						t_q <= trial_index;
						v_q <= voxel_index;
					end
				end
				ST_SUM: if (!last_k) k_q <= k_q + 1'b1;
				ST_MUL: begin
					if (ph_q == PH_C2) begin
						ph_q <= '0;
						k_q  <= '0;
						if (!last_row) i_q <= i_q + 1'b1;
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_BIG_WAIT: if (mul_done) bp_q <= bp_q + 1'b1;
				default: ;
			endcase
		end
	end

	// row sum and element capture from the registered reads
	logic                    dv_s1;
	logic                    dt_s1;
	logic signed [S_W-1:0]   s_q;
	logic signed [VAL_W-1:0] c_q;
	logic signed [VAL_W-1:0] y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1 <= 1'b0;
			dt_s1 <= 1'b0;
		end else begin
			dv_s1 <= state_q == ST_SUM;
			dt_s1 <= k_q[TRIAL_W-1:0] == t_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE || (state_q == ST_MUL && ph_q == PH_C2)) begin
			s_q <= '0;
		end else if (dv_s1) begin
			s_q <= s_q + S_W'(design_rd_q);
		end
		if (dv_s1 && dt_s1) c_q <= design_rd_q;
		if (state_q == ST_YWAIT) y_q <= data_rd_q;
	end

	// shared row multiplier, one product per cycle
	logic signed [S_W-1:0]    ma;
	logic signed [S_W-1:0]    mb;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     pv_s1;
	logic [2:0]               pph_s1;

	always_comb begin
		ma = s_q;
		mb = s_q;
		case (ph_q)
			PH_SS:  begin ma = s_q;          mb = s_q;          end
			PH_CTY: begin ma = S_W'(c_q);    mb = S_W'(y_q);    end
			PH_CS:  begin ma = S_W'(c_q);    mb = s_q;          end
			PH_SCY: begin ma = s_q;          mb = S_W'(y_q);    end
			PH_C2:  begin ma = S_W'(c_q);    mb = S_W'(c_q);    end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1  <= 1'b0;
			pph_s1 <= '0;
		end else begin
			pv_s1  <= state_q == ST_MUL;
			pph_s1 <= ph_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
	end

	// accumulators
	logic [SS_W-1:0]         ss_q;
	logic signed [CTY_W-1:0] cty_q;
	logic signed [CS_W-1:0]  cs_q;
	logic signed [CS_W-1:0]  scy_q;
	logic signed [C2_W-1:0]  c2_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			ss_q  <= '0;
			cty_q <= '0;
			cs_q  <= '0;
			scy_q <= '0;
			c2_q  <= '0;
		end else if (pv_s1) begin
			case (pph_s1)
				PH_SS:  ss_q  <= ss_q + {{(SS_W-PROD_W){1'b0}}, prod_s1};
				PH_CTY: cty_q <= cty_q + CTY_W'(prod_s1);
				PH_CS:  cs_q  <= cs_q + CS_W'(prod_s1);
				PH_SCY: scy_q <= scy_q + CS_W'(prod_s1);
				PH_C2:  c2_q  <= c2_q + C2_W'(prod_s1);
				default: ;
			endcase
		end
	end

	// wide products through the serial multiplier
	logic [CTY_W-1:0]    cty_mag;
	logic [CS_W-1:0]     cs_mag;
	logic [CS_W-1:0]     scy_mag;
	logic [MUL_W-1:0]    wa;
	logic [MUL_W-1:0]    wb;
	logic                wneg;
	logic [2*MUL_W-1:0]  mul_prod;
	logic [NUM_W-1:0]    pmag;
	logic signed [NUM_W-1:0] psig;
	logic signed [NUM_W-1:0] num_q;
	logic signed [NUM_W-1:0] den_q;

	assign cty_mag = cty_q[CTY_W-1] ? CTY_W'(-cty_q) : CTY_W'(cty_q);
	assign cs_mag  = cs_q[CS_W-1]   ? CS_W'(-cs_q)   : CS_W'(cs_q);
	assign scy_mag = scy_q[CS_W-1]  ? CS_W'(-scy_q)  : CS_W'(scy_q);

	always_comb begin
		wa   = MUL_W'(cty_mag);
		wb   = ss_q;
		wneg = 1'b0;
		case (bp_q)
			BP_CTY_SS: begin
				wa = MUL_W'(cty_mag); wb = ss_q; wneg = cty_q[CTY_W-1];
			end
			BP_CS_SCY: begin
				wa = MUL_W'(cs_mag); wb = MUL_W'(scy_mag);
				wneg = cs_q[CS_W-1] ^ scy_q[CS_W-1];
			end
			BP_C2_SS: begin
				wa = MUL_W'(c2_q); wb = ss_q; wneg = 1'b0;
			end
			BP_CS_CS: begin
				wa = MUL_W'(cs_mag); wb = MUL_W'(cs_mag); wneg = 1'b0;
			end
			default: ;
		endcase
	end

	lss_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (wa),
		.b      (wb),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign pmag = mul_prod[NUM_W-1:0];
	assign psig = wneg ? -$signed(pmag) : $signed(pmag);

	always_ff @(posedge clk) begin
		if (state_q == ST_BIG_WAIT && mul_done) begin
			case (bp_q)
				BP_CTY_SS: num_q <= psig;
				BP_CS_SCY: num_q <= num_q - psig;
				BP_C2_SS:  den_q <= psig;
				BP_CS_CS:  den_q <= den_q - psig;
				default: ;
			endcase
		end
	end

	// magnitudes, floor check and rounded quotient
	logic [NUM_W-1:0] an;
	logic [NUM_W-1:0] ad;
	logic             neg_q;
	logic [DN_W-1:0]  div_num;
	logic [DD_W-1:0]  div_den;
	logic [DN_W-1:0]  div_quo;

	assign an        = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign ad        = den_q[NUM_W-1] ? NUM_W'(-den_q) : NUM_W'(den_q);
	assign undef_now = (ad == '0) || (ad < NUM_W'(min_den_q));
	assign div_num   = {an, {QF_SH{1'b0}}} + DN_W'(ad);
	assign div_den   = {ad, 1'b0};

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) neg_q <= num_q[NUM_W-1] ^ den_q[NUM_W-1];
	end

	lss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic [BETA_W-1:0] lim;
	logic              over;
	logic [BETA_W-1:0] qsat;
	assign lim  = neg_q ? LIM_NEG : LIM_POS;
	assign over = (|div_quo[DN_W-1:BETA_W]) || (div_quo[BETA_W-1:0] > lim);
	assign qsat = over ? lim : div_quo[BETA_W-1:0];

	// result register, one-cycle strobe
	logic                    done_q;
	logic signed [BETA_W-1:0] beta_q;
	logic                    undef_q;
	logic [TRIAL_W-1:0]      trial_out_q;
	logic [VOX_W-1:0]        voxel_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && req_type == REQ_QUERY && !q_in_range)
			       || (state_q == ST_CHECK && undef_now)
			       || (state_q == ST_DIV_WAIT && div_done);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_QUERY && !q_in_range) begin
			beta_q      <= '0;
			undef_q     <= 1'b1;
			trial_out_q <= trial_index;
			voxel_out_q <= voxel_index;
		end else if (state_q == ST_CHECK && undef_now) begin
			beta_q      <= '0;
			undef_q     <= 1'b1;
			trial_out_q <= t_q;
			voxel_out_q <= v_q;
		end else if (state_q == ST_DIV_WAIT && div_done) begin
			beta_q      <= neg_q ? $signed(-qsat) : $signed(qsat);
			undef_q     <= 1'b0;
			trial_out_q <= t_q;
			voxel_out_q <= v_q;
		end
	end

	assign done      = done_q;
	assign beta      = beta_q;
	assign undefined = undef_q;
	assign trial_out = trial_out_q;
	assign voxel_out = voxel_out_q;

	// checks
	a_sum_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (k_q < trials_eff))
		else $error("trial counter past trials in use");

	a_defined_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !undefined) |-> $past(state_q == ST_DIV_WAIT))
		else $error("defined beta not from divider");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (ph_q <= PH_C2))
		else $error("row product phase out of range");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(design_we || data_we) |-> (state_q == ST_IDLE))
		else $error("store written during a query");
endmodule
